// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the NEC pulse decoder RTL.
// Uses the clk and rst names of the module that includes this file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define NEC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define NEC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/nec_pd_pkg.sv -----
// Types and constants for the NEC pulse decoder.
// No dependencies; imported by nec_pd_core and nec_pulse_decoder_top.
package nec_pd_pkg;

  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_DATA   = 2'd1,
    PH_REPEAT = 2'd2
  } phase_t;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_SHORT    = 4'd1,
    ST_NOHDR    = 4'd2,
    ST_REPEAT   = 4'd3,
    ST_TRUNC    = 4'd4,
    ST_MARK     = 4'd5,
    ST_SPACELVL = 4'd6,
    ST_SPACELEN = 4'd7,
    ST_ADDRCHK  = 4'd8,
    ST_CMDCHK   = 4'd9
  } status_t;

  localparam logic [2:0] PULSES_MIN  = 3'd4;
  localparam logic [6:0] DATA_PULSES = 7'd64;

  // Duration windows in microseconds, inclusive.
  localparam logic [15:0] HDR_MARK_LO  = 16'd7800;
  localparam logic [15:0] HDR_MARK_HI  = 16'd10200;
  localparam logic [15:0] HDR_DATA_LO  = 16'd3800;
  localparam logic [15:0] HDR_DATA_HI  = 16'd5200;
  localparam logic [15:0] HDR_REP_LO   = 16'd1750;
  localparam logic [15:0] HDR_REP_HI   = 16'd2750;
  localparam logic [15:0] BIT_MARK_LO  = 16'd300;
  localparam logic [15:0] BIT_MARK_HI  = 16'd820;
  localparam logic [15:0] BIT_ZERO_LO  = 16'd200;
  localparam logic [15:0] BIT_ZERO_HI  = 16'd920;
  localparam logic [15:0] BIT_ONE_LO   = 16'd1330;
  localparam logic [15:0] BIT_ONE_HI   = 16'd2050;

  typedef struct packed {
    logic        level;
    logic [15:0] length;
    logic        fin;
  } pulse_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] addr;
    logic [7:0] cmd;
  } result_t;

endpackage

// ----- hdl/nec_pulse_decoder_top.sv -----
// Top level of the NEC pulse decoder: input register, decode core, result register.
// Depends on nec_pd_pkg, nec_pd_core and assert_macros.svh.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   input   | in_valid / in_ready  | pulse_level, pulse_length, final_pulse
//   output  | out_valid / out_ready| status, device_address, command_code
//
// One pulse per cycle sustained unless a final pulse waits on a full result register;
// a final pulse's result is registered into the result register as it leaves the input
// register. Each held pulse is decoded and the frame state updated in the same cycle.
// Reset clears the frame state and both valid flags.
// A final pulse waits in the input register only while the result register is
// full and not taken; other pulses never wait on the output side.
`include "assert_macros.svh"

module nec_pulse_decoder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        pulse_level,
  input  logic [15:0] pulse_length,
  input  logic        final_pulse,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  status,
  output logic [7:0]  device_address,
  output logic [7:0]  command_code
);
  import nec_pd_pkg::*;

  logic    in_full;
  pulse_t  in_reg;
  logic    advance;
  result_t core_res;
  result_t out_reg;

  // a non-final pulse never needs the result slot
  assign advance  = in_full && (!in_reg.fin || !out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_reg.level  <= pulse_level;
      in_reg.length <= pulse_length;
      in_reg.fin    <= final_pulse;
    end
  end

  nec_pd_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .pulse  (in_reg),
    .result (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_reg.fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_reg.fin) begin
      out_reg <= core_res;
    end
  end

  assign status         = 4'(out_reg.status);
  assign device_address = out_reg.addr;
  assign command_code   = out_reg.cmd;

  `NEC_ASSERT_IMP(a_stall_cause, !in_ready,
    in_full && in_reg.fin && out_valid && !out_ready,
    "input stalled without a waiting final result")
  `NEC_ASSERT_IMP(a_err_zero, out_valid && out_reg.status != ST_OK,
    out_reg.addr == 8'd0 && out_reg.cmd == 8'd0,
    "failed frame carries nonzero address or command")

endmodule

// ----- hdl/nec_pd_core.sv -----
// Frame state and per-pulse decode for the NEC pulse decoder.
// Depends on nec_pd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module nec_pd_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  nec_pd_pkg::pulse_t  pulse,
  output nec_pd_pkg::result_t result
);
  import nec_pd_pkg::*;

  phase_t      phase, phase_next;
  logic        prior_level;
  logic [15:0] prior_length;
  logic        have_prior;
  logic [2:0]  pulses_seen, pulses_seen_next;
  logic        mark_polarity, mark_polarity_next;
  logic        space_polarity, space_polarity_next;
  logic [6:0]  pulses_after_header, pulses_after_header_next;
  logic [31:0] frame_bits, frame_bits_next;
  status_t     first_error, first_error_next;

  logic        hdr_mark_ok;
  logic        is_space;
  logic [4:0]  bit_idx;
  status_t     status_c;

  always_comb begin
    phase_next               = phase;
    mark_polarity_next       = mark_polarity;
    space_polarity_next      = space_polarity;
    pulses_after_header_next = pulses_after_header;
    frame_bits_next          = frame_bits;
    first_error_next         = first_error;
    pulses_seen_next = (pulses_seen < PULSES_MIN) ? pulses_seen + 3'd1 : pulses_seen;

    hdr_mark_ok = have_prior && (prior_level != pulse.level) &&
                  (prior_length inside {[HDR_MARK_LO:HDR_MARK_HI]});
    is_space    = pulses_after_header[0];
    bit_idx     = pulses_after_header[5:1];

    case (phase)
      PH_SEARCH: begin
        if (hdr_mark_ok) begin
          if (pulse.length inside {[HDR_DATA_LO:HDR_DATA_HI]}) begin
            phase_next               = PH_DATA;
            mark_polarity_next       = prior_level;
            space_polarity_next      = pulse.level;
            pulses_after_header_next = '0;
            frame_bits_next          = '0;
            first_error_next         = ST_OK;
          end else if (pulse.length inside {[HDR_REP_LO:HDR_REP_HI]}) begin
            phase_next          = PH_REPEAT;
            mark_polarity_next  = prior_level;
            space_polarity_next = pulse.level;
          end
        end
      end
      PH_DATA: begin
        if (pulses_after_header < DATA_PULSES) begin
          // keep only the earliest bit error
          if (first_error == ST_OK) begin
            if (!is_space) begin
              if (pulse.level != mark_polarity ||
                  !(pulse.length inside {[BIT_MARK_LO:BIT_MARK_HI]}))
                first_error_next = ST_MARK;
            end else if (pulse.level != space_polarity) begin
              first_error_next = ST_SPACELVL;
            end else if (pulse.length inside {[BIT_ZERO_LO:BIT_ZERO_HI]}) begin
              frame_bits_next = frame_bits;
            end else if (pulse.length inside {[BIT_ONE_LO:BIT_ONE_HI]}) begin
              frame_bits_next[bit_idx] = 1'b1;
            end else begin
              first_error_next = ST_SPACELEN;
            end
          end
          pulses_after_header_next = pulses_after_header + 7'd1;
        end
      end
      default: begin
      end
    endcase

    // status reflects the state after this pulse
    if (pulses_seen_next < PULSES_MIN)
      status_c = ST_SHORT;
    else if (phase_next == PH_SEARCH)
      status_c = ST_NOHDR;
    else if (phase_next == PH_REPEAT)
      status_c = ST_REPEAT;
    else if (pulses_after_header_next < DATA_PULSES)
      status_c = ST_TRUNC;
    else if (first_error_next != ST_OK)
      status_c = first_error_next;
    else if (frame_bits_next[7:0] != ~frame_bits_next[15:8])
      status_c = ST_ADDRCHK;
    else if (frame_bits_next[23:16] != ~frame_bits_next[31:24])
      status_c = ST_CMDCHK;
    else
      status_c = ST_OK;

    result.status = status_c;
    result.addr   = (status_c == ST_OK) ? frame_bits_next[7:0]   : 8'd0;
    result.cmd    = (status_c == ST_OK) ? frame_bits_next[23:16] : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && pulse.fin)) begin
      // a final pulse closes the capture
      phase               <= PH_SEARCH;
      prior_level         <= 1'b0;
      prior_length        <= '0;
      have_prior          <= 1'b0;
      pulses_seen         <= '0;
      mark_polarity       <= 1'b0;
      space_polarity      <= 1'b0;
      pulses_after_header <= '0;
      frame_bits          <= '0;
      first_error         <= ST_OK;
    end else if (fire) begin
      phase               <= phase_next;
      prior_level         <= pulse.level;
      prior_length        <= pulse.length;
      have_prior          <= 1'b1;
      pulses_seen         <= pulses_seen_next;
      mark_polarity       <= mark_polarity_next;
      space_polarity      <= space_polarity_next;
      pulses_after_header <= pulses_after_header_next;
      frame_bits          <= frame_bits_next;
      first_error         <= first_error_next;
    end
  end

  `NEC_ASSERT_NXT(a_fin_clears, fire && pulse.fin,
    phase == PH_SEARCH && pulses_seen == 3'd0 && !have_prior,
    "final pulse did not clear capture state")
  `NEC_ASSERT_IMP(a_idle_data, phase != PH_DATA,
    pulses_after_header == 7'd0 && frame_bits == 32'd0 && first_error == ST_OK,
    "data state moved outside the data phase")
  `NEC_ASSERT_IMP(a_sat, 1'b1,
    pulses_seen <= PULSES_MIN && pulses_after_header <= DATA_PULSES,
    "pulse counter passed its saturation point")

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for nec_pulse_decoder_top: directed and random IR captures.
// Depends on nec_pd_pkg; predicts status, address and command of every capture itself.
module testbench;
  import nec_pd_pkg::*;

  typedef struct packed {
    logic        level;
    logic [15:0] length;
    logic        fin;
    logic        hold;    // send only once every outstanding result has arrived
  } stim_pulse_t;

  typedef struct packed {
    status_t    st;
    logic [7:0] addr;
    logic [7:0] cmd;
  } frame_result_t;

  typedef enum int {
    FK_GOOD, FK_ADDR_BAD, FK_CMD_BAD, FK_MARK_LEVEL, FK_MARK_LEN, FK_SPACE_LEVEL,
    FK_SPACE_LEN, FK_TRUNCATED, FK_REPEAT, FK_NEAR_MISS, FK_NOISE
  } frame_kind_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        pulse_level = 1'b0;
  logic [15:0] pulse_length = 16'd0;
  logic        final_pulse = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  status;
  logic [7:0]  device_address;
  logic [7:0]  command_code;

  nec_pulse_decoder_top u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .pulse_level    (pulse_level),
    .pulse_length   (pulse_length),
    .final_pulse    (final_pulse),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .device_address (device_address),
    .command_code   (command_code)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  stim_pulse_t   pending_pulses[$];
  frame_result_t expected_frames[$];
  int            mismatch_count = 0;
  int            pulses_accepted = 0;
  int            results_checked = 0;
  int            captures_queued = 0;
  int            status_hits[10];
  int            cycle_no = 0;
  bit            pulse_taken = 1'b0;

  // Decoder state as the predictor sees it
  phase_t        scan_phase;
  logic          last_level;
  logic [15:0]   last_length;
  logic          last_valid;
  int            pulse_tally;
  logic          hdr_mark_level;
  logic          hdr_space_level;
  int            data_pulses;
  logic [31:0]   frame_word;
  status_t       first_fault;

  task automatic flag_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 50) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  function automatic bit in_window(logic [15:0] v, logic [15:0] lo, logic [15:0] hi);
    return v >= lo && v <= hi;
  endfunction

  task automatic clear_frame_state();
    scan_phase      = PH_SEARCH;
    last_level      = 1'b0;
    last_length     = 16'd0;
    last_valid      = 1'b0;
    pulse_tally     = 0;
    hdr_mark_level  = 1'b0;
    hdr_space_level = 1'b0;
    data_pulses     = 0;
    frame_word      = 32'd0;
    first_fault     = ST_OK;
  endtask

  task automatic decode_pulse(input logic lvl, input logic [15:0] len, input logic fin);
    frame_result_t res;
    if (pulse_tally < PULSES_MIN) pulse_tally++;
    case (scan_phase)
      PH_SEARCH: begin
        // Header: opposite-level pair, long mark first
        if (last_valid && last_level != lvl &&
            in_window(last_length, HDR_MARK_LO, HDR_MARK_HI)) begin
          if (in_window(len, HDR_DATA_LO, HDR_DATA_HI)) begin
            scan_phase      = PH_DATA;
            hdr_mark_level  = last_level;
            hdr_space_level = lvl;
            data_pulses     = 0;
            frame_word      = 32'd0;
            first_fault     = ST_OK;
          end else if (in_window(len, HDR_REP_LO, HDR_REP_HI)) begin
            scan_phase      = PH_REPEAT;
            hdr_mark_level  = last_level;
            hdr_space_level = lvl;
          end
        end
      end
      PH_DATA: begin
        if (data_pulses < DATA_PULSES) begin
          if (first_fault == ST_OK) begin
            if (data_pulses % 2 == 0) begin
              if (lvl != hdr_mark_level || !in_window(len, BIT_MARK_LO, BIT_MARK_HI)) begin
                first_fault = ST_MARK;
              end
            end else if (lvl != hdr_space_level) begin
              first_fault = ST_SPACELVL;
            end else if (!in_window(len, BIT_ZERO_LO, BIT_ZERO_HI)) begin
              if (in_window(len, BIT_ONE_LO, BIT_ONE_HI)) begin
                frame_word[data_pulses / 2] = 1'b1;
              end else begin
                first_fault = ST_SPACELEN;
              end
            end
          end
          data_pulses++;
        end
      end
      default: ;
    endcase
    last_level  = lvl;
    last_length = len;
    last_valid  = 1'b1;

    if (fin) begin
      if (pulse_tally < PULSES_MIN) res.st = ST_SHORT;
      else if (scan_phase == PH_SEARCH) res.st = ST_NOHDR;
      else if (scan_phase == PH_REPEAT) res.st = ST_REPEAT;
      else if (data_pulses < DATA_PULSES) res.st = ST_TRUNC;
      else if (first_fault != ST_OK) res.st = first_fault;
      else if (frame_word[7:0] != ~frame_word[15:8]) res.st = ST_ADDRCHK;
      else if (frame_word[23:16] != ~frame_word[31:24]) res.st = ST_CMDCHK;
      else res.st = ST_OK;
      res.addr = (res.st == ST_OK) ? frame_word[7:0] : 8'd0;
      res.cmd  = (res.st == ST_OK) ? frame_word[23:16] : 8'd0;
      expected_frames.push_back(res);
      clear_frame_state();
    end
  endtask

  // Stimulus helpers
  function automatic logic [15:0] pick_within(int lo, int hi);
    case ($urandom_range(0, 3))
      0: return 16'(lo);
      1: return 16'(hi);
      default: return 16'($urandom_range(hi, lo));
    endcase
  endfunction

  function automatic logic [15:0] pick_outside(int lo, int hi);
    case ($urandom_range(0, 3))
      0: return 16'(lo - 1);
      1: return 16'(hi + 1);
      2: return 16'($urandom_range(lo - 1, 0));
      default: return 16'($urandom_range(65535, hi + 1));
    endcase
  endfunction

  // Space length that is neither a zero nor a one
  function automatic logic [15:0] pick_bad_space();
    case ($urandom_range(0, 6))
      0: return 16'(BIT_ZERO_LO - 1);
      1: return 16'(BIT_ZERO_HI + 1);
      2: return 16'(BIT_ONE_LO - 1);
      3: return 16'(BIT_ONE_HI + 1);
      4: return 16'($urandom_range(BIT_ZERO_LO - 1, 0));
      5: return 16'($urandom_range(BIT_ONE_LO - 1, BIT_ZERO_HI + 1));
      default: return 16'($urandom_range(65535, BIT_ONE_HI + 1));
    endcase
  endfunction

  function automatic stim_pulse_t random_pulse();
    stim_pulse_t p;
    p.level  = 1'($urandom_range(0, 1));
    p.length = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                           : 16'($urandom_range(0, 12000));
    p.fin    = 1'b0;
    p.hold   = 1'b0;
    return p;
  endfunction

  task automatic send_capture(frame_kind_t kind, bit hold);
    stim_pulse_t burst[$];
    stim_pulse_t p;
    logic        mark_lv;
    logic [7:0]  addr;
    logic [7:0]  cmd;
    logic [31:0] word;
    logic        lvl;
    logic [15:0] len;
    int          n_data;
    int          bad_at;
    int          miss;

    mark_lv = 1'($urandom_range(0, 1));
    addr    = 8'($urandom);
    cmd     = 8'($urandom);
    word    = {~cmd, cmd, ~addr, addr};
    if (kind == FK_ADDR_BAD) word[8 + $urandom_range(0, 7)] ^= 1'b1;
    if (kind == FK_CMD_BAD) word[24 + $urandom_range(0, 7)] ^= 1'b1;
    miss = $urandom_range(0, 2);

    if (kind == FK_NOISE) begin
      repeat ($urandom_range(1, 8)) burst.push_back(random_pulse());
    end else begin
      repeat ($urandom_range(0, 2)) burst.push_back(random_pulse());
      len = pick_within(HDR_MARK_LO, HDR_MARK_HI);
      if (kind == FK_NEAR_MISS && miss == 0) len = pick_outside(HDR_MARK_LO, HDR_MARK_HI);
      burst.push_back('{mark_lv, len, 1'b0, 1'b0});

      lvl = ~mark_lv;
      if (kind == FK_REPEAT) len = pick_within(HDR_REP_LO, HDR_REP_HI);
      else len = pick_within(HDR_DATA_LO, HDR_DATA_HI);
      if (kind == FK_NEAR_MISS && miss == 1) begin
        case ($urandom_range(0, 3))
          0: len = HDR_REP_LO - 16'd1;
          1: len = HDR_REP_HI + 16'd1;
          2: len = HDR_DATA_LO - 16'd1;
          default: len = HDR_DATA_HI + 16'd1;
        endcase
      end
      if (kind == FK_NEAR_MISS && miss == 2) lvl = mark_lv;
      burst.push_back('{lvl, len, 1'b0, 1'b0});

      if (kind == FK_REPEAT) begin
        repeat ($urandom_range(0, 3)) burst.push_back(random_pulse());
      end else begin
        n_data = (kind == FK_TRUNCATED) ? $urandom_range(0, 63) : 64;
        bad_at = $urandom_range(0, 31) * 2 +
                 ((kind == FK_SPACE_LEVEL || kind == FK_SPACE_LEN) ? 1 : 0);
        for (int j = 0; j < n_data; j++) begin
          if (j % 2 == 0) begin
            lvl = mark_lv;
            len = pick_within(BIT_MARK_LO, BIT_MARK_HI);
          end else begin
            lvl = ~mark_lv;
            len = word[j / 2] ? pick_within(BIT_ONE_LO, BIT_ONE_HI)
                              : pick_within(BIT_ZERO_LO, BIT_ZERO_HI);
          end
          if (j == bad_at) begin
            case (kind)
              FK_MARK_LEVEL, FK_SPACE_LEVEL: lvl = ~lvl;
              FK_MARK_LEN: len = pick_outside(BIT_MARK_LO, BIT_MARK_HI);
              FK_SPACE_LEN: len = pick_bad_space();
              default: ;
            endcase
          end
          burst.push_back('{lvl, len, 1'b0, 1'b0});
        end
        // Stop mark and stray pulses past the data are ignored
        if (kind != FK_TRUNCATED) repeat ($urandom_range(0, 2)) burst.push_back(random_pulse());
      end
    end

    p = burst.pop_back();
    p.fin = 1'b1;
    burst.push_back(p);
    p = burst.pop_front();
    p.hold = hold;
    burst.push_front(p);
    foreach (burst[k]) pending_pulses.push_back(burst[k]);
    captures_queued++;
  endtask

  function automatic bit steady_window();
    return cycle_no >= 400 && cycle_no < 1400;
  endfunction

  // Drive inputs on the falling edge
  always @(negedge clk) begin : drive
    stim_pulse_t nxt;
    bit          busy;
    busy = in_valid && !pulse_taken;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!busy) begin
      if (pending_pulses.size() != 0 &&
          !(pending_pulses[0].hold && expected_frames.size() != 0) &&
          (steady_window() || $urandom_range(0, 99) >= 8)) begin
        nxt = pending_pulses.pop_front();
        in_valid     <= 1'b1;
        pulse_level  <= nxt.level;
        pulse_length <= nxt.length;
        final_pulse  <= nxt.fin;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= steady_window() || $urandom_range(0, 99) >= 8;
  end

  // Check results first, then predict from the pulse taken at this edge
  always @(posedge clk) begin : watch
    frame_result_t want;
    if (rst) begin
      clear_frame_state();
      pulse_taken = 1'b0;
    end else begin
      cycle_no++;
      if (out_valid && out_ready) begin
        if (expected_frames.size() == 0) begin
          flag_mismatch($sformatf("unexpected result, status %0d", status));
        end else begin
          want = expected_frames.pop_front();
          results_checked++;
          status_hits[int'(want.st)]++;
          if (status !== want.st) begin
            flag_mismatch($sformatf("status got %0d want %0d", status, want.st));
          end
          if (device_address !== want.addr) begin
            flag_mismatch($sformatf("address got %0h want %0h", device_address, want.addr));
          end
          if (command_code !== want.cmd) begin
            flag_mismatch($sformatf("command got %0h want %0h", command_code, want.cmd));
          end
        end
      end
      pulse_taken = in_valid && in_ready;
      if (pulse_taken) begin
        pulses_accepted++;
        decode_pulse(pulse_level, pulse_length, final_pulse);
      end
    end
  end

  initial begin
    frame_kind_t kind;
    int          pick;
    string       hist;
    status_t     st;

    foreach (status_hits[k]) status_hits[k] = 0;

    // Lone final pulse, three-pulse capture, extremes with no header
    pending_pulses.push_back('{1'b0, 16'd0, 1'b1, 1'b0});
    pending_pulses.push_back('{1'b1, 16'd65535, 1'b0, 1'b0});
    pending_pulses.push_back('{1'b0, 16'd0, 1'b0, 1'b0});
    pending_pulses.push_back('{1'b1, 16'd65535, 1'b1, 1'b0});
    pending_pulses.push_back('{1'b1, 16'd65535, 1'b0, 1'b0});
    pending_pulses.push_back('{1'b0, 16'd0, 1'b0, 1'b0});
    pending_pulses.push_back('{1'b1, 16'd32768, 1'b0, 1'b0});
    pending_pulses.push_back('{1'b0, 16'd65535, 1'b1, 1'b0});
    // Repeat header
    pending_pulses.push_back('{1'b1, 16'd9000, 1'b0, 1'b0});
    pending_pulses.push_back('{1'b0, 16'd2250, 1'b0, 1'b0});
    pending_pulses.push_back('{1'b1, 16'd560, 1'b0, 1'b0});
    pending_pulses.push_back('{1'b0, 16'd40000, 1'b1, 1'b0});
    // Data header cut short
    pending_pulses.push_back('{1'b0, 16'd100, 1'b0, 1'b0});
    pending_pulses.push_back('{1'b1, 16'd9000, 1'b0, 1'b0});
    pending_pulses.push_back('{1'b0, 16'd4500, 1'b0, 1'b0});
    pending_pulses.push_back('{1'b1, 16'd560, 1'b1, 1'b0});
    captures_queued = 5;

    // One capture of each kind, then a random mix
    for (int k = FK_GOOD; k <= FK_NOISE; k++) send_capture(frame_kind_t'(k), 1'b0);
    while (pending_pulses.size() < 2000 || captures_queued < 40) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) kind = FK_GOOD;
      else if (pick < 38) kind = FK_ADDR_BAD;
      else if (pick < 45) kind = FK_CMD_BAD;
      else if (pick < 52) kind = FK_MARK_LEVEL;
      else if (pick < 59) kind = FK_MARK_LEN;
      else if (pick < 66) kind = FK_SPACE_LEVEL;
      else if (pick < 73) kind = FK_SPACE_LEN;
      else if (pick < 81) kind = FK_TRUNCATED;
      else if (pick < 87) kind = FK_REPEAT;
      else if (pick < 93) kind = FK_NEAR_MISS;
      else kind = FK_NOISE;
      send_capture(kind, captures_queued % 10 == 3);
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending_pulses.size() != 0 || in_valid || expected_frames.size() != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);

    hist = "";
    for (int k = 0; k < 10; k++) begin
      st = status_t'(k);
      hist = {hist, $sformatf(" %s=%0d", st.name(), status_hits[k])};
    end
    $display("covered %0d pulses over %0d captures, %0d results compared",
             pulses_accepted, captures_queued, results_checked);
    $display("results by status:%s", hist);
    if (mismatch_count == 0) begin
      $display("PASS nec_pulse_decoder_top");
    end else begin
      $display("FAIL nec_pulse_decoder_top");
    end
    $finish;
  end

  initial begin
    #(20 * 400000);
    $display("timeout with %0d results still outstanding", expected_frames.size());
    $display("FAIL nec_pulse_decoder_top");
    $finish;
  end

endmodule
